// ===== rtl/core/fmc_pkg.sv =====
`timescale 1ns / 1ps

package fmc_pkg;

  localparam logic [7:0]  NEWLINE_CHAR  = 8'd10;
  localparam logic [7:0]  DIGIT_MAX     = 8'd57;
  localparam logic [15:0] ASCII_ZERO    = 16'd48;
  localparam logic [15:0] ALPHA_OFFSET  = 16'd87;
  localparam logic [8:0]  FLETCHER_MOD  = 9'd255;

  localparam logic [3:0] POS_HDR_FIRST  = 4'd1;
  localparam logic [3:0] POS_HDR_LAST   = 4'd4;
  localparam logic [3:0] POS_SUM_START  = 4'd5;
  localparam logic [3:0] POS_TID_FIRST  = 4'd6;
  localparam logic [3:0] POS_TID_LAST   = 4'd8;
  localparam logic [3:0] POS_MIN_LAST   = 4'd9;
  localparam logic [3:0] POS_PAYLOAD    = 4'd10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } msg_item_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_done;
    logic        checksum_good;
    logic [15:0] transaction_id;
    logic [15:0] received_sum;
    logic [15:0] computed_sum;
  } result_item_t;

  // one step of the frame tracker
  typedef struct packed {
    logic      step;
    msg_item_t item;
  } step_req_t;

  typedef struct packed {
    logic         emit;
    result_item_t item;
  } step_rsp_t;

  // bytes are taken as signed: top half maps to b - 304
  function automatic logic [15:0] hex_digit(input logic [7:0] b);
    logic [15:0] d;
    if (b[7]) begin
      d = {8'hFF, b} - ASCII_ZERO;
    end else if (b <= DIGIT_MAX) begin
      d = {8'h00, b} - ASCII_ZERO;
    end else begin
      d = {8'h00, b} - ALPHA_OFFSET;
    end
    return d;
  endfunction

  // operands below 255 on a, so one subtract suffices
  function automatic logic [7:0] mod255_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= FLETCHER_MOD) begin
      s = s - FLETCHER_MOD;
    end
    return s[7:0];
  endfunction

endpackage

// ===== rtl/core/fmc_stream_if.sv =====
`timescale 1ns / 1ps

interface fmc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/fmc_frame_state.sv =====
`timescale 1ns / 1ps

module fmc_frame_state import fmc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  step_req_t req,
  output step_rsp_t rsp
);

  logic [3:0]  byte_position;
  logic [15:0] header_sum_acc;
  logic [15:0] tid_acc;
  logic [7:0]  first_sum;
  logic [7:0]  second_sum;
  logic        newline_seen;

  logic [3:0]  byte_position_next;
  logic [15:0] header_sum_acc_next;
  logic [15:0] tid_acc_next;
  logic [7:0]  first_sum_next;
  logic [7:0]  second_sum_next;
  logic        newline_seen_next;

  logic [7:0]  b;
  logic        fwd;
  logic        last;
  logic [15:0] comp;

  always_comb begin
    b    = req.item.data_byte;
    last = req.item.end_of_message;
    fwd  = (byte_position >= POS_PAYLOAD);

    header_sum_acc_next = header_sum_acc;
    tid_acc_next        = tid_acc;
    first_sum_next      = first_sum;
    second_sum_next     = second_sum;
    newline_seen_next   = newline_seen;

    if (byte_position >= POS_HDR_FIRST && byte_position <= POS_HDR_LAST) begin
      header_sum_acc_next = {header_sum_acc[11:0], 4'h0} + hex_digit(b);
    end else if (byte_position >= POS_TID_FIRST && byte_position <= POS_TID_LAST) begin
      tid_acc_next = {tid_acc[11:0], 4'h0} + hex_digit(b);
    end

    if (byte_position >= POS_SUM_START && !newline_seen) begin
      if (b == NEWLINE_CHAR) begin
        newline_seen_next = 1'b1;
      end else begin
        first_sum_next  = mod255_add(first_sum, b);
        second_sum_next = mod255_add(second_sum, first_sum_next);
      end
    end

    byte_position_next = fwd ? byte_position : byte_position + 4'd1;
    comp = {second_sum_next, first_sum_next};

    rsp.emit = fwd || last;
    rsp.item = '0;
    if (fwd) begin
      rsp.item.payload_valid = 1'b1;
      rsp.item.payload_byte  = b;
    end
    if (last) begin
      rsp.item.frame_done     = 1'b1;
      rsp.item.checksum_good  = (byte_position >= POS_MIN_LAST) &&
                                (comp == header_sum_acc_next);
      rsp.item.transaction_id = tid_acc_next;
      rsp.item.received_sum   = header_sum_acc_next;
      rsp.item.computed_sum   = comp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (req.step && last)) begin
      byte_position  <= '0;
      header_sum_acc <= '0;
      tid_acc        <= '0;
      first_sum      <= '0;
      second_sum     <= '0;
      newline_seen   <= 1'b0;
    end else if (req.step) begin
      byte_position  <= byte_position_next;
      header_sum_acc <= header_sum_acc_next;
      tid_acc        <= tid_acc_next;
      first_sum      <= first_sum_next;
      second_sum     <= second_sum_next;
      newline_seen   <= newline_seen_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_PAYLOAD)
    else $error("byte position past payload start");

  a_sums_reduced: assert property (@(posedge clk) disable iff (rst)
    first_sum != 8'd255 && second_sum != 8'd255)
    else $error("fletcher sum not reduced");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    req.step && last |=> byte_position == '0 && !newline_seen)
    else $error("state not cleared after final byte");

endmodule

// ===== rtl/core/fletcher_framed_message_checker_unit.sv =====
`timescale 1ns / 1ps

// channel   dir  payload          fields
// message   in   msg_item_t       data_byte, end_of_message
// result    out  result_item_t    payload_valid/byte, frame_done, checksum_good, tid, sums
//
// one byte per cycle sustained while the result is not stalled; a byte passes from the
// input register through the frame state into the result register
// bytes that give no result (header bytes that do not end the frame) retire without using the output
// rst is synchronous and clears both valid flags and the frame state
// a stalled result holds the input register when its byte gives a result; the input side still takes a byte
// while its register is empty or drains in the same cycle

module fletcher_framed_message_checker_unit import fmc_pkg::*; (
  input logic          clk,
  input logic          rst,
  fmc_stream_if.sink   message,
  fmc_stream_if.source result
);

  logic         s1_valid;
  msg_item_t    s1_item;
  logic         res_valid;
  result_item_t res_item;

  logic      out_free;
  logic      s1_advance;
  logic      take;
  step_req_t req;
  step_rsp_t rsp;

  assign out_free   = !res_valid || result.ready;
  assign s1_advance = s1_valid && (!rsp.emit || out_free);
  assign take       = message.valid && message.ready;

  assign message.ready = !s1_valid || s1_advance;

  assign req.step = s1_advance;
  assign req.item = s1_item;

  fmc_frame_state u_frame_state (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item <= message.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_advance && rsp.emit) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && rsp.emit) begin
      res_item <= rsp.item;
    end
  end

  assign result.valid   = res_valid;
  assign result.payload = res_item;

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid && $stable(s1_item))
    else $error("input register lost a stalled byte");

  a_good_needs_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.checksum_good |-> res_item.frame_done)
    else $error("checksum verdict without frame end");

  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.payload_valid |-> res_item.payload_byte == 8'd0)
    else $error("payload byte set without payload flag");

  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_item.payload_valid || res_item.frame_done)
    else $error("empty result presented");

endmodule
